// File: src/lhkc_pkg.sv
package lhkc_pkg;

    localparam int KW_COUNT     = 31;
    localparam int KW_OBS_COUNT = 2;
    localparam int KW_MAX_CHARS = 14;
    localparam int KW_BITS      = 8 * KW_MAX_CHARS;
    localparam int LEN_W        = 4;

    localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;

    localparam logic [1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLS_OBS     = 2'd1;
    localparam logic [1:0] CLS_NAV     = 2'd2;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_TOKEN = 3'b010,
        PH_DONE  = 3'b100
    } t_phase;

    // Keywords are right-justified: the first character sits in the highest used byte.
    // The first KW_OBS_COUNT entries are observation logs, the rest navigation logs.
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        "RANGEA", "OBSVMA",
        "GLOEPHEMERISA", "GALEPHEMERISA", "GPSEPHEMA", "GPSION", "GPSIONA",
        "GPSEPH", "GPSEPHA", "GLOEPH", "GLOEPHA", "GALEPH", "GALEPHA",
        "GALION", "GALIONA",
        "QZSSEPHEMERISA", "QZSSEPH", "QZSSEPHA",
        "BD2EPHEMA", "BD2IONUTCA", "BD3ION", "BD3IONA", "BDSION", "BDSIONA",
        "BD3EPH", "BD3EPHA", "BDSEPH", "BDSEPHA",
        "IONUTCA", "IRNSSEPH", "IRNSSEPHA"
    };

    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd6,
        4'd13, 4'd13, 4'd9, 4'd6, 4'd7,
        4'd6, 4'd7, 4'd6, 4'd7, 4'd6, 4'd7,
        4'd6, 4'd7,
        4'd14, 4'd7, 4'd8,
        4'd9, 4'd10, 4'd6, 4'd7, 4'd6, 4'd7,
        4'd6, 4'd7, 4'd6, 4'd7,
        4'd7, 4'd8, 4'd9
    };

    // Character at position pos of keyword k, or zero beyond its end.
    function automatic logic [7:0] kw_char(input int k, input logic [LEN_W-1:0] pos);
        int base;
        base = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        if (pos < KW_LEN[k]) begin
            return KW_TEXT[k][base +: 8];
        end
        return 8'h00;
    endfunction

endpackage

// File: src/log_header_keyword_classifier.sv
// Log header keyword classifier. Feed the bytes of one receiver log sentence,
// one byte per request, and mark the final byte with i_last_byte. A '#' in the
// first position is skipped; the header token then runs up to a comma,
// semicolon, CR, LF, space, tab or the final byte, and as soon as it ends one
// result is delivered: 1 for an observation log (RANGEA, OBSVMA), 2 for one of
// the 29 navigation keywords, 0 for anything else, including an empty token.
// Bytes after the token produce nothing until the final byte, which readies the
// parser for the next sentence. Exactly one result comes out per sentence. The
// block takes one byte every cycle when not stalled: a byte is captured in the
// input register, compared against all keywords in parallel, and its result, if
// any, is written to the result register that drives o_valid. While a result
// waits on a stalled output, the byte held in the input register waits as well
// and the input side is stalled, whether or not that byte would produce a
// result. No clearing pass is needed after reset.
module log_header_keyword_classifier
    import lhkc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_sentence_class
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parser state.
    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [KW_COUNT-1:0] r_alive, n_alive;

    // Result register.
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_class, n_out_class;

    logic                advance;
    logic                fire;
    logic                active;
    logic                is_delim;
    logic                skip_hash;
    logic                take;
    logic                ended;
    logic [LEN_W-1:0]    len_taken;
    logic [KW_COUNT-1:0] alive_taken;
    logic [KW_COUNT-1:0] match;
    logic [1:0]          cls;

    // The processing stage moves whenever the result register is free or is
    // being emptied in this cycle.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    always_comb begin
        is_delim  = r_in_byte inside {CH_COMMA, CH_SEMI, CH_CR, CH_LF, CH_SPACE, CH_TAB};
        active    = (r_phase == PH_START) || (r_phase == PH_TOKEN);
        skip_hash = (r_phase == PH_START) && (r_in_byte == CH_HASH);
        take      = active && !skip_hash && !is_delim;
        ended     = active && (r_in_last || (!skip_hash && is_delim));
    end

    // Every keyword checks its own character at the current position.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            alive_taken[k] = r_alive[k] && (r_len < KW_LEN[k]) &&
                             (kw_char(k, r_len) == r_in_byte);
        end
        len_taken = (r_len < LEN_MAX) ? r_len + 4'd1 : r_len;
    end

    // A keyword matches when it is still alive and the token is exactly its length.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            match[k] = n_alive[k] && (n_len == KW_LEN[k]);
        end
        if (|match[KW_OBS_COUNT-1:0]) begin
            cls = CLS_OBS;
        end else if (|match[KW_COUNT-1:KW_OBS_COUNT]) begin
            cls = CLS_NAV;
        end else begin
            cls = CLS_UNKNOWN;
        end
    end

    always_comb begin
        n_len   = take ? len_taken : r_len;
        n_alive = take ? alive_taken : r_alive;
        n_phase = r_phase;
        if (ended) begin
            n_phase = PH_DONE;
        end else if (active) begin
            n_phase = PH_TOKEN;
        end

        n_out_valid = r_out_valid && i_stall;
        n_out_class = r_out_class;
        if (fire && ended) begin
            n_out_valid = 1'b1;
            n_out_class = cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_START;
            r_len       <= '0;
            r_alive     <= '1;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            r_out_valid <= n_out_valid;
            if (fire) begin
                if (r_in_last) begin
                    // The final byte always readies the parser for a new sentence.
                    r_phase <= PH_START;
                    r_len   <= '0;
                    r_alive <= '1;
                end else begin
                    r_phase <= n_phase;
                    r_len   <= n_len;
                    r_alive <= n_alive;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
        r_out_class <= n_out_class;
    end

    assign o_valid          = r_out_valid;
    assign o_sentence_class = r_out_class;

    // An empty token has eliminated no keyword.
    a_empty_all_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) |-> (r_alive == '1))
        else $error("keyword eliminated before any token byte");

    // At sentence start no token byte has been counted.
    a_start_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |-> (r_len == '0))
        else $error("token length non-zero at sentence start");

    // The final byte always returns the parser to sentence start.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_phase == PH_START))
        else $error("final byte did not restart the parser");

    // A result is never a code outside the three classes.
    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_class != 2'd3))
        else $error("illegal class code delivered");

    // A result is only produced while parsing, never after the token has ended.
    a_no_result_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_phase == PH_DONE)) |=> (r_out_valid == $past(r_out_valid && i_stall)))
        else $error("result produced after the token had ended");

endmodule
